@@ rtl/ptc_pkg.sv @@
// Shared constants, register index codes and a helper function for the
// pressure and temperature compensation core. No dependencies.
package ptc_pkg;

    localparam int unsigned RAW_W      = 24;
    localparam int unsigned COEFF_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned PRESS_W    = 32;
    localparam int unsigned TEMP_W     = 20;
    localparam int unsigned PIPE_DEPTH = 11;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_VLOW = -1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS     = 3'd0,
        REG_OFF      = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5,
        REG_MODEL    = 3'd6
    } cfg_reg_t;

    // Signed division by 2**k that truncates toward zero; k is a constant
    // at every call site, so this is a bias add and an arithmetic shift.
    function automatic logic signed [63:0] div_pow2(input logic signed [63:0] x,
                                                    input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

@@ rtl/pressure_temperature_compensation_core.sv @@
// Second-order pressure and temperature compensation core, eleven stages.
// Depends on ptc_pkg for widths, register codes and the truncating divider.
// done is the valid bit of the last stage; the pipeline accepts one request per cycle.
// busy is never asserted, since the pipeline always advances; the receiver must
// take every result in the cycle that done is high (the block does not enforce it).
// Reset clears the calibration registers to zero and empties the pipeline.
module pressure_temperature_compensation_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ptc_pkg::RAW_W-1:0]          raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]          raw_temperature,
    output logic                               done,
    output logic signed [ptc_pkg::PRESS_W-1:0] pressure_out,
    output logic signed [ptc_pkg::TEMP_W-1:0]  temperature_out,
    input  logic                               cfg_write,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptc_pkg::COEFF_W-1:0]        cfg_data
);
    import ptc_pkg::*;

    // Calibration registers.
    logic [COEFF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic               two_bar_reg;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    // Stage 1
    logic signed [24:0] dt_reg, dt_next;
    logic [RAW_W-1:0]   d1_s1_reg;
    // Stage 2
    logic signed [41:0] tcs_dt_reg, tcs_dt_next, tco_dt_reg, tco_dt_next;
    logic signed [41:0] c6_dt_reg, c6_dt_next;
    logic signed [49:0] dtsq_full;
    logic [48:0]        dtsq_reg, dtsq_next;
    logic [RAW_W-1:0]   d1_s2_reg;
    // Stage 3
    logic signed [63:0] sens_base, off_base, sens_adj, off_adj;
    logic signed [35:0] sens1_reg, sens1_next;
    logic signed [37:0] off1_reg, off1_next;
    logic signed [18:0] temp1_reg, temp1_next;
    logic [48:0]        dtsq_s3_reg;
    logic [RAW_W-1:0]   d1_s3_reg;
    // Stage 4
    logic signed [18:0] dl, dv;
    logic signed [37:0] dlsq_full, dvsq_full;
    logic [33:0]        dlsq_reg, dlsq_next, dvsq_reg, dvsq_next;
    logic               low_reg, low_next, vlow_reg, vlow_next;
    logic [52:0]        dtsq_x11, dtsq_x3;
    logic [16:0]        ti_reg, ti_next;
    logic signed [18:0] temp1_s4_reg;
    logic signed [35:0] sens1_s4_reg;
    logic signed [37:0] off1_s4_reg;
    logic [RAW_W-1:0]   d1_s4_reg;
    // Stage 5
    logic [37:0]        offi_reg, offi_next;
    logic [36:0]        sensi_reg, sensi_next;
    logic signed [20:0] temp2;
    logic signed [TEMP_W-1:0] temp_s5_reg, temp_s5_next;
    logic signed [35:0] sens1_s5_reg;
    logic signed [37:0] off1_s5_reg;
    logic [RAW_W-1:0]   d1_s5_reg;
    // Stage 6
    logic signed [38:0] sens2_reg, sens2_next;
    logic signed [39:0] off2_reg, off2_next;
    logic signed [TEMP_W-1:0] temp_s6_reg;
    logic [RAW_W-1:0]   d1_s6_reg;
    // Stage 7
    logic [43:0]        pplo_reg, pplo_next;
    logic signed [43:0] pphi_reg, pphi_next;
    logic signed [39:0] off2_s7_reg;
    logic signed [TEMP_W-1:0] temp_s7_reg;
    // Stage 8
    logic signed [63:0] prod_reg, prod_next;
    logic signed [39:0] off2_s8_reg;
    logic signed [TEMP_W-1:0] temp_s8_reg;
    // Stage 9
    logic signed [42:0] pdiv_reg, pdiv_next;
    logic signed [39:0] off2_s9_reg;
    logic signed [TEMP_W-1:0] temp_s9_reg;
    // Stage 10
    logic signed [44:0] pdiff_reg, pdiff_next;
    logic signed [TEMP_W-1:0] temp_s10_reg;
    // Stage 11
    logic signed [63:0] pq;
    logic signed [PRESS_W-1:0] press_reg, press_next;
    logic signed [TEMP_W-1:0]  temp_out_reg;

    assign busy            = 1'b0;
    assign done            = vld_reg[PIPE_DEPTH-1];
    assign pressure_out    = press_reg;
    assign temperature_out = temp_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg      <= '0;
            c2_reg      <= '0;
            c3_reg      <= '0;
            c4_reg      <= '0;
            c5_reg      <= '0;
            c6_reg      <= '0;
            two_bar_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SENS:     c1_reg      <= cfg_data;
                REG_OFF:      c2_reg      <= cfg_data;
                REG_TCS:      c3_reg      <= cfg_data;
                REG_TCO:      c4_reg      <= cfg_data;
                REG_TREF:     c5_reg      <= cfg_data;
                REG_TEMPSENS: c6_reg      <= cfg_data;
                REG_MODEL:    two_bar_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        // Stage 1: temperature difference from the reference.
        dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_reg, 8'd0});

        // Stage 2: first-order products and dT squared.
        tcs_dt_next = dt_reg * $signed({1'b0, c3_reg});
        tco_dt_next = dt_reg * $signed({1'b0, c4_reg});
        c6_dt_next  = dt_reg * $signed({1'b0, c6_reg});
        dtsq_full   = dt_reg * dt_reg;
        dtsq_next   = dtsq_full[48:0];

        // Stage 3: first-order SENS, OFF and TEMP.
        sens_base  = two_bar_reg ? $signed(64'(c1_reg) << 16) : $signed(64'(c1_reg) << 15);
        off_base   = two_bar_reg ? $signed(64'(c2_reg) << 17) : $signed(64'(c2_reg) << 16);
        sens_adj   = two_bar_reg ? div_pow2(64'(tcs_dt_reg), 7) : div_pow2(64'(tcs_dt_reg), 8);
        off_adj    = two_bar_reg ? div_pow2(64'(tco_dt_reg), 6) : div_pow2(64'(tco_dt_reg), 7);
        sens1_next = 36'(sens_base + sens_adj);
        off1_next  = 38'(off_base + off_adj);
        temp1_next = 19'(64'(TEMP_REF) + div_pow2(64'(c6_dt_reg), 23));

        // Stage 4: squares of the temperature offsets and the TEMP correction.
        dl        = temp1_reg - 19'(TEMP_REF);
        dv        = temp1_reg - 19'(TEMP_VLOW);
        dlsq_full = dl * dl;
        dvsq_full = dv * dv;
        dlsq_next = dlsq_full[33:0];
        dvsq_next = dvsq_full[33:0];
        low_next  = temp1_reg < 19'(TEMP_REF);
        vlow_next = temp1_reg < 19'(TEMP_VLOW);
        dtsq_x11  = (53'(dtsq_s3_reg) << 3) + (53'(dtsq_s3_reg) << 1) + 53'(dtsq_s3_reg);
        dtsq_x3   = (53'(dtsq_s3_reg) << 1) + 53'(dtsq_s3_reg);
        if (two_bar_reg)
        begin
            ti_next = low_next ? 17'(dtsq_x11 >> 35) : 17'd0;
        end
        else
        begin
            ti_next = low_next ? 17'(dtsq_x3 >> 33) : 17'(dtsq_s3_reg >> 36);
        end

        // Stage 5: OFF and SENS corrections, final temperature with clamp.
        if (two_bar_reg)
        begin
            offi_next  = low_reg ? 38'(((42'(dlsq_reg) << 5) - 42'(dlsq_reg)) >> 3) : 38'd0;
            sensi_next = low_reg ? 37'(((42'(dlsq_reg) << 6) - 42'(dlsq_reg)) >> 5) : 37'd0;
        end
        else if (low_reg)
        begin
            offi_next  = 38'(((38'(dlsq_reg) << 1) + 38'(dlsq_reg)) >> 1);
            sensi_next = 37'(((38'(dlsq_reg) << 2) + 38'(dlsq_reg)) >> 3);
            if (vlow_reg)
            begin
                offi_next  = offi_next + (38'(dvsq_reg) << 3) - 38'(dvsq_reg);
                sensi_next = sensi_next + (37'(dvsq_reg) << 2);
            end
        end
        else
        begin
            offi_next  = 38'(dlsq_reg >> 4);
            sensi_next = 37'd0;
        end
        temp2 = 21'(temp1_s4_reg) - $signed({4'd0, ti_reg});
        if (temp2 < -21'sd524288)
        begin
            temp_s5_next = {1'b1, {(TEMP_W-1){1'b0}}};
        end
        else if (temp2 > 21'sd524287)
        begin
            temp_s5_next = {1'b0, {(TEMP_W-1){1'b1}}};
        end
        else
        begin
            temp_s5_next = 20'(temp2);
        end

        // Stage 6: second-order SENS and OFF.
        sens2_next = 39'(sens1_s5_reg) - $signed({2'd0, sensi_reg});
        off2_next  = 40'(off1_s5_reg) - $signed({2'd0, offi_reg});

        // Stage 7: D1 * SENS2 split into two partial products.
        pplo_next = 44'(d1_s6_reg) * 44'(sens2_reg[19:0]);
        pphi_next = $signed({1'b0, d1_s6_reg}) * $signed(sens2_reg[38:20]);

        // Stage 8: combine the partial products.
        prod_next = (64'(pphi_reg) <<< 20) + $signed({20'd0, pplo_reg});

        // Stage 9 and 10: scale the product and remove the offset.
        pdiv_next  = 43'(div_pow2(prod_reg, 21));
        pdiff_next = 45'(pdiv_reg) - 45'(off2_s9_reg);

        // Stage 11: final scaling and saturation to 32 bits.
        pq = two_bar_reg ? div_pow2(64'(pdiff_reg), 15) : div_pow2(64'(pdiff_reg), 13);
        if (pq < -64'sd2147483648)
        begin
            press_next = {1'b1, {(PRESS_W-1){1'b0}}};
        end
        else if (pq > 64'sd2147483647)
        begin
            press_next = {1'b0, {(PRESS_W-1){1'b1}}};
        end
        else
        begin
            press_next = 32'(pq);
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        d1_s1_reg    <= raw_pressure;

        tcs_dt_reg   <= tcs_dt_next;
        tco_dt_reg   <= tco_dt_next;
        c6_dt_reg    <= c6_dt_next;
        dtsq_reg     <= dtsq_next;
        d1_s2_reg    <= d1_s1_reg;

        sens1_reg    <= sens1_next;
        off1_reg     <= off1_next;
        temp1_reg    <= temp1_next;
        dtsq_s3_reg  <= dtsq_reg;
        d1_s3_reg    <= d1_s2_reg;

        dlsq_reg     <= dlsq_next;
        dvsq_reg     <= dvsq_next;
        low_reg      <= low_next;
        vlow_reg     <= vlow_next;
        ti_reg       <= ti_next;
        temp1_s4_reg <= temp1_reg;
        sens1_s4_reg <= sens1_reg;
        off1_s4_reg  <= off1_reg;
        d1_s4_reg    <= d1_s3_reg;

        offi_reg     <= offi_next;
        sensi_reg    <= sensi_next;
        temp_s5_reg  <= temp_s5_next;
        sens1_s5_reg <= sens1_s4_reg;
        off1_s5_reg  <= off1_s4_reg;
        d1_s5_reg    <= d1_s4_reg;

        sens2_reg    <= sens2_next;
        off2_reg     <= off2_next;
        temp_s6_reg  <= temp_s5_reg;
        d1_s6_reg    <= d1_s5_reg;

        pplo_reg     <= pplo_next;
        pphi_reg     <= pphi_next;
        off2_s7_reg  <= off2_reg;
        temp_s7_reg  <= temp_s6_reg;

        prod_reg     <= prod_next;
        off2_s8_reg  <= off2_s7_reg;
        temp_s8_reg  <= temp_s7_reg;

        pdiv_reg     <= pdiv_next;
        off2_s9_reg  <= off2_s8_reg;
        temp_s9_reg  <= temp_s8_reg;

        pdiff_reg    <= pdiff_next;
        temp_s10_reg <= temp_s9_reg;

        press_reg    <= press_next;
        temp_out_reg <= temp_s10_reg;
    end

endmodule
